@@ design/ntg_pkg.sv @@
package ntg_pkg;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_MODULUS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE_ROOT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MONT_FACTOR = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INVERSE_N   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Q_INVERSE   = 3'd4;

    localparam logic [14:0] RST_MODULUS     = 15'd3329;
    localparam logic [14:0] RST_BASE_ROOT   = 15'd17;
    localparam logic [14:0] RST_MONT_FACTOR = 15'd1353;
    localparam logic [14:0] RST_INVERSE_N   = 15'd3303;
    localparam logic [31:0] RST_Q_INVERSE   = 32'd1806234369;

    // barrett reciprocal floor(2^30 / q) for the reset modulus
    localparam logic [30:0] RST_MU = 31'((64'd1 << 30) / {49'd0, RST_MODULUS});

    typedef logic [2:0] t_op;
    localparam t_op OP_NOP    = 3'd0;
    localparam t_op OP_MUL_AB = 3'd1;
    localparam t_op OP_MUL_MU = 3'd2;
    localparam t_op OP_MUL_M  = 3'd3;
    localparam t_op OP_RED    = 3'd4;
    localparam t_op OP_CTR    = 3'd5;
    localparam t_op OP_MUL_Q  = 3'd6;
    localparam t_op OP_DONE   = 3'd7;

    typedef logic [1:0] t_opsel;
    localparam t_opsel OPS_ACC_SQ   = 2'd0;
    localparam t_opsel OPS_SQ_SQ    = 2'd1;
    localparam t_opsel OPS_ACC_MF   = 2'd2;
    localparam t_opsel OPS_ACC_INVN = 2'd3;

    typedef logic t_dst;
    localparam t_dst DST_ACC = 1'b0;
    localparam t_dst DST_SQ  = 1'b1;

    typedef logic [1:0] t_jmp;
    localparam t_jmp JMP_NONE     = 2'd0;
    localparam t_jmp JMP_BIT_CLR  = 2'd1;
    localparam t_jmp JMP_LOOP     = 2'd2;
    localparam t_jmp JMP_NO_SCALE = 2'd3;

    typedef logic [4:0] t_pc;

    typedef struct packed {
        t_op    op;
        t_opsel opsel;
        t_dst   dst;
        logic   shift;
        t_jmp   jmp;
        t_pc    target;
    } t_uword;

    typedef struct packed {
        logic exp_bit;
        logic scale;
        logic out_stall;
    } t_stat;

    localparam t_uword UW_NOP = '{op: OP_NOP, opsel: OPS_ACC_SQ, dst: DST_ACC,
                                  shift: 1'b0, jmp: JMP_NONE, target: 5'd0};

    function automatic t_uword uw(t_op op, t_opsel opsel, t_dst dst, logic shift,
                                  t_jmp jmp, t_pc target);
        t_uword w;
        w.op     = op;
        w.opsel  = opsel;
        w.dst    = dst;
        w.shift  = shift;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    // microprogram: each modular product is five steps
    // (magnitude product, times mu, times q, subtract and correct, center)
    function automatic t_uword ucode_rom(t_pc pc);
        t_uword w;
        w = UW_NOP;
        unique case (pc)
            // exponent loop: acc *= sq when the bit is set, then sq *= sq
            5'd0:  w = uw(OP_NOP,    OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_BIT_CLR,  5'd6);
            5'd1:  w = uw(OP_MUL_AB, OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd2:  w = uw(OP_MUL_MU, OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd3:  w = uw(OP_MUL_M,  OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd4:  w = uw(OP_RED,    OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd5:  w = uw(OP_CTR,    OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd6:  w = uw(OP_MUL_AB, OPS_SQ_SQ,    DST_SQ,  1'b0, JMP_NONE,     5'd0);
            5'd7:  w = uw(OP_MUL_MU, OPS_SQ_SQ,    DST_SQ,  1'b0, JMP_NONE,     5'd0);
            5'd8:  w = uw(OP_MUL_M,  OPS_SQ_SQ,    DST_SQ,  1'b0, JMP_NONE,     5'd0);
            5'd9:  w = uw(OP_RED,    OPS_SQ_SQ,    DST_SQ,  1'b0, JMP_NONE,     5'd0);
            5'd10: w = uw(OP_CTR,    OPS_SQ_SQ,    DST_SQ,  1'b1, JMP_LOOP,     5'd0);
            // factor step
            5'd11: w = uw(OP_MUL_AB, OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd12: w = uw(OP_MUL_MU, OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd13: w = uw(OP_MUL_M,  OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd14: w = uw(OP_RED,    OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd15: w = uw(OP_CTR,    OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NO_SCALE, 5'd26);
            // scale mode: factor again, then inverse n
            5'd16: w = uw(OP_MUL_AB, OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd17: w = uw(OP_MUL_MU, OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd18: w = uw(OP_MUL_M,  OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd19: w = uw(OP_RED,    OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd20: w = uw(OP_CTR,    OPS_ACC_MF,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd21: w = uw(OP_MUL_AB, OPS_ACC_INVN, DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd22: w = uw(OP_MUL_MU, OPS_ACC_INVN, DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd23: w = uw(OP_MUL_M,  OPS_ACC_INVN, DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd24: w = uw(OP_RED,    OPS_ACC_INVN, DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd25: w = uw(OP_CTR,    OPS_ACC_INVN, DST_ACC, 1'b0, JMP_NONE,     5'd0);
            // companion product and result
            5'd26: w = uw(OP_MUL_Q,  OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            5'd27: w = uw(OP_DONE,   OPS_ACC_SQ,   DST_ACC, 1'b0, JMP_NONE,     5'd0);
            default: w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

@@ design/ntg_recip.sv @@
module ntg_recip (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [14:0] i_modulus,
    output logic        o_busy,
    output logic [30:0] o_mu
);
    import ntg_pkg::*;

    // restoring division of 2^30 by q, one quotient bit per cycle
    logic        r_busy;
    logic [4:0]  r_cnt;
    logic [14:0] r_rem;
    logic [30:0] r_q;
    logic [15:0] rem_sh;
    logic        ge;

    always_comb begin
        rem_sh = {r_rem, r_cnt == 5'd0};
        ge     = rem_sh >= {1'b0, i_modulus};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_q    <= RST_MU;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
            r_rem  <= '0;
            r_q    <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? 15'(rem_sh - {1'b0, i_modulus}) : rem_sh[14:0];
            r_q   <= {r_q[29:0], ge};
            r_cnt <= 5'(r_cnt + 5'd1);
            if (r_cnt == 5'd30) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy = r_busy;
    assign o_mu   = r_q;

endmodule

@@ design/ntg_seq.sv @@
module ntg_seq #(
    parameter int EXP_BITS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ntg_pkg::t_stat  i_stat,
    output ntg_pkg::t_uword o_uword,
    output logic            o_busy
);
    import ntg_pkg::*;

    localparam int CNT_W = $clog2(EXP_BITS + 1);

    logic             r_busy;
    t_pc              r_pc;
    logic [CNT_W-1:0] r_cnt;
    t_uword           uword;
    logic             taken;
    logic             last_bit;

    always_comb begin
        uword    = r_busy ? ucode_rom(r_pc) : UW_NOP;
        last_bit = r_cnt == CNT_W'(EXP_BITS - 1);
        unique case (uword.jmp)
            JMP_NONE:     taken = 1'b0;
            JMP_BIT_CLR:  taken = !i_stat.exp_bit;
            JMP_LOOP:     taken = !last_bit;
            JMP_NO_SCALE: taken = !i_stat.scale;
            default:      taken = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pc   <= '0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_pc   <= '0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (uword.op == OP_DONE) begin
                if (!i_stat.out_stall) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_pc <= taken ? uword.target : t_pc'(r_pc + 5'd1);
                if (uword.shift) begin
                    r_cnt <= CNT_W'(r_cnt + 1'b1);
                end
            end
        end
    end

    assign o_uword = uword;
    assign o_busy  = r_busy;

endmodule

@@ design/ntg_datapath.sv @@
module ntg_datapath #(
    parameter int EXP_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [EXP_BITS-1:0] i_exponent,
    input  logic                i_scale_mode,
    input  logic [14:0]         i_modulus,
    input  logic [14:0]         i_base_root,
    input  logic [14:0]         i_mont_factor,
    input  logic [14:0]         i_inverse_n,
    input  logic [31:0]         i_q_inverse,
    input  logic [30:0]         i_mu,
    input  ntg_pkg::t_uword     i_uword,
    input  logic                i_out_ready,
    output ntg_pkg::t_stat      o_stat,
    output logic                o_out_valid,
    output logic signed [14:0]  o_twiddle,
    output logic [31:0]         o_twiddle_qinv
);
    import ntg_pkg::*;

    logic signed [15:0]  r_acc;
    logic signed [15:0]  r_sq;
    logic [EXP_BITS-1:0] r_exp;
    logic                r_scale;
    logic [63:0]         r_prod;
    logic [29:0]         r_x;
    logic                r_neg;
    logic [14:0]         r_rem;
    logic                r_out_valid;
    logic signed [14:0]  r_twiddle;
    logic [31:0]         r_twiddle_qinv;

    logic signed [15:0] op_a;
    logic signed [15:0] op_b;
    logic [15:0]        mag_a;
    logic [15:0]        mag_b;
    logic [31:0]        mul_x;
    logic [31:0]        mul_y;
    logic               mul_en;
    logic [63:0]        prod_next;
    logic [30:0]        diff;
    logic [15:0]        d16;
    logic [14:0]        rem_next;
    logic signed [16:0] t_s;
    logic signed [16:0] m_s;
    logic signed [16:0] half_s;
    logic signed [16:0] t1;
    logic signed [16:0] t2;
    logic signed [15:0] ctr_res;
    logic               out_stall;
    logic               done_fire;

    // operand select
    always_comb begin
        unique case (i_uword.opsel)
            OPS_ACC_SQ: begin
                op_a = r_acc;
                op_b = r_sq;
            end
            OPS_SQ_SQ: begin
                op_a = r_sq;
                op_b = r_sq;
            end
            OPS_ACC_MF: begin
                op_a = r_acc;
                op_b = $signed({1'b0, i_mont_factor});
            end
            OPS_ACC_INVN: begin
                op_a = r_acc;
                op_b = $signed({1'b0, i_inverse_n});
            end
            default: begin
                op_a = r_acc;
                op_b = r_sq;
            end
        endcase
        mag_a = op_a[15] ? 16'(-op_a) : op_a;
        mag_b = op_b[15] ? 16'(-op_b) : op_b;
    end

    // the one shared multiplier
    always_comb begin
        mul_en = 1'b1;
        unique case (i_uword.op)
            OP_MUL_AB: begin
                mul_x = {16'd0, mag_a};
                mul_y = {16'd0, mag_b};
            end
            OP_MUL_MU: begin
                mul_x = {2'd0, r_prod[29:0]};
                mul_y = {1'b0, i_mu};
            end
            OP_MUL_M: begin
                mul_x = {2'd0, r_prod[59:30]};
                mul_y = {17'd0, i_modulus};
            end
            OP_MUL_Q: begin
                mul_x = {{16{r_acc[15]}}, r_acc};
                mul_y = i_q_inverse;
            end
            default: begin
                mul_x  = '0;
                mul_y  = '0;
                mul_en = 1'b0;
            end
        endcase
        prod_next = {32'd0, mul_x} * {32'd0, mul_y};
    end

    // barrett remainder: x - qest*q lies in [0, 2q)
    always_comb begin
        diff     = {1'b0, r_x} - r_prod[30:0];
        d16      = diff[15:0];
        rem_next = (d16 >= {1'b0, i_modulus}) ? 15'(d16 - {1'b0, i_modulus}) : d16[14:0];
    end

    // sign of truncating remainder, then centering
    always_comb begin
        t_s     = r_neg ? -$signed({2'b00, r_rem}) : $signed({2'b00, r_rem});
        m_s     = $signed({2'b00, i_modulus});
        half_s  = $signed({3'b000, i_modulus[14:1]});
        t1      = (t_s >= half_s) ? 17'(t_s - m_s) : t_s;
        t2      = (t1 < -half_s) ? 17'(t1 + m_s) : t1;
        ctr_res = (i_modulus == 15'd0) ? 16'sd0 : t2[15:0];
    end

    assign out_stall = r_out_valid && !i_out_ready;
    assign done_fire = (i_uword.op == OP_DONE) && !out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc   <= 16'sd1;
            r_sq    <= $signed({1'b0, i_base_root});
            r_exp   <= i_exponent;
            r_scale <= i_scale_mode;
        end else begin
            if (i_uword.shift) begin
                r_exp <= r_exp >> 1;
            end
            if (i_uword.op == OP_CTR) begin
                if (i_uword.dst == DST_SQ) begin
                    r_sq <= ctr_res;
                end else begin
                    r_acc <= ctr_res;
                end
            end
        end
        if (mul_en) begin
            r_prod <= prod_next;
        end
        if (i_uword.op == OP_MUL_AB) begin
            r_neg <= op_a[15] ^ op_b[15];
        end
        if (i_uword.op == OP_MUL_MU) begin
            r_x <= r_prod[29:0];
        end
        if (i_uword.op == OP_RED) begin
            r_rem <= rem_next;
        end
        if (done_fire) begin
            r_twiddle      <= r_acc[14:0];
            r_twiddle_qinv <= r_prod[31:0];
        end
    end

    assign o_stat.exp_bit   = r_exp[0];
    assign o_stat.scale     = r_scale;
    assign o_stat.out_stall = out_stall;
    assign o_out_valid      = r_out_valid;
    assign o_twiddle        = r_twiddle;
    assign o_twiddle_qinv   = r_twiddle_qinv;

endmodule

@@ design/ntt_twiddle_generator.sv @@
// ntt twiddle generator: base_root^exponent by square-and-multiply, centered mod q, times factor
//   (in scale mode times factor again and inverse n), and that result also times q inverse
// requests are taken one at a time: the microcoded sequencer (five steps per product) takes
//   no new request until the last result has been handed to the output register
// a modulus write starts a reciprocal division; no request is taken meanwhile
// synchronous active-low reset restores register defaults and the reset-modulus reciprocal
module ntt_twiddle_generator #(
    parameter int EXP_BITS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // request channel
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [EXP_BITS-1:0] i_exponent,
    input  logic                i_scale_mode,
    // result channel
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic signed [14:0]  o_twiddle,
    output logic [31:0]         o_twiddle_qinv,
    // configuration write port
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_idx,
    input  logic [31:0]         i_cfg_data
);
    import ntg_pkg::*;

    // configuration registers
    logic [14:0] r_modulus;
    logic [14:0] r_base_root;
    logic [14:0] r_mont_factor;
    logic [14:0] r_inverse_n;
    logic [31:0] r_q_inverse;

    logic        recip_start;
    logic        recip_busy;
    logic [30:0] mu;
    logic        seq_busy;
    logic        start;
    t_uword      uword;
    t_stat       stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus     <= RST_MODULUS;
            r_base_root   <= RST_BASE_ROOT;
            r_mont_factor <= RST_MONT_FACTOR;
            r_inverse_n   <= RST_INVERSE_N;
            r_q_inverse   <= RST_Q_INVERSE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MODULUS:     r_modulus     <= i_cfg_data[14:0];
                REG_BASE_ROOT:   r_base_root   <= i_cfg_data[14:0];
                REG_MONT_FACTOR: r_mont_factor <= i_cfg_data[14:0];
                REG_INVERSE_N:   r_inverse_n   <= i_cfg_data[14:0];
                REG_Q_INVERSE:   r_q_inverse   <= i_cfg_data;
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    // a new modulus needs a fresh barrett reciprocal; the unit reads
    // r_modulus from the cycle after the write on
    assign recip_start = i_cfg_we && (i_cfg_idx == REG_MODULUS);

    // take a request only when the sequencer and the reciprocal unit are both free and no
    // modulus write is under way; a finished result may still be waiting at the output
    assign o_in_ready = !seq_busy && !recip_busy && !recip_start;
    assign start      = i_in_valid && o_in_ready;

    ntg_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (recip_start),
        .i_modulus (r_modulus),
        .o_busy    (recip_busy),
        .o_mu      (mu)
    );

    // step counter, microcode table and jump logic
    ntg_seq #(
        .EXP_BITS (EXP_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_uword (uword),
        .o_busy  (seq_busy)
    );

    // operand registers, shared multiplier, reduction and output register
    ntg_datapath #(
        .EXP_BITS (EXP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_exponent     (i_exponent),
        .i_scale_mode   (i_scale_mode),
        .i_modulus      (r_modulus),
        .i_base_root    (r_base_root),
        .i_mont_factor  (r_mont_factor),
        .i_inverse_n    (r_inverse_n),
        .i_q_inverse    (r_q_inverse),
        .i_mu           (mu),
        .i_uword        (uword),
        .i_out_ready    (i_out_ready),
        .o_stat         (stat),
        .o_out_valid    (o_out_valid),
        .o_twiddle      (o_twiddle),
        .o_twiddle_qinv (o_twiddle_qinv)
    );

`ifndef ASSERT_OFF
    // an accepted request keeps the port closed on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> !o_in_ready)
        else $error("request accepted while sequencer idle afterwards");

    // a modulus write blocks requests while the reciprocal is rebuilt
    a_recip_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        recip_start |=> recip_busy && !o_in_ready)
        else $error("reciprocal not rebuilt after modulus write");

    // a new result only appears at the end of a sequencer run
    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(seq_busy))
        else $error("result without a running request");

    // centered values never reach the most negative code
    a_twiddle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_twiddle != 15'sh4000)
        else $error("twiddle outside the centered range");
`endif

endmodule

@@ bench/testbench.sv @@
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import ntg_pkg::*;

    localparam int EXP_W = 8;
    // indexes past the register list; writes to them must change nothing
    localparam logic [2:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [2:0] REG_SPARE_LAST  = 3'd7;
    // cycles with no handshake or register write before the run is declared hung
    // (worst case is a long sender gap, the reciprocal divide, a full request's work
    // and a long receiver stall back to back, well under this)
    localparam int HANG_LIMIT      = 3000;
    localparam int SETTLE_CYCLES   = 120;
    localparam int RANDOM_PHASES   = 13;
    localparam int PHASE_REQUESTS  = 98;
    localparam int MAX_PRINTED     = 40;

    // expected result of one request, with the request kept for messages
    typedef struct {
        logic [EXP_W-1:0]   exponent;
        logic               scale;
        logic signed [14:0] twiddle;
        logic [31:0]        qinv;
    } t_twiddle_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [EXP_W-1:0]    i_exponent;
    logic                i_scale_mode;
    logic                o_out_valid;
    logic                i_out_ready = 1'b1;
    logic signed [14:0]  o_twiddle;
    logic [31:0]         o_twiddle_qinv;
    logic                i_cfg_we;
    logic [2:0]          i_cfg_idx;
    logic [31:0]         i_cfg_data;

    // shadow copy of the configuration registers
    logic [14:0] q_mod;
    logic [14:0] root_reg;
    logic [14:0] mont_reg;
    logic [14:0] invn_reg;
    logic [31:0] qinv_reg;

    t_twiddle_result twiddle_expected[$];
    int  mismatch_count  = 0;
    int  requests_sent   = 0;
    int  results_checked = 0;
    int  settings_used   = 0;
    int  stall_left      = 0;
    int  quiet_cycles    = 0;
    bit  idle_on         = 1'b1;

    ntt_twiddle_generator #(.EXP_BITS(EXP_W)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_exponent     (i_exponent),
        .i_scale_mode   (i_scale_mode),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_twiddle      (o_twiddle),
        .o_twiddle_qinv (o_twiddle_qinv),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // centered modular product: truncating remainder, then fold into
    // [-floor(q/2), floor(q/2)]; a zero modulus gives zero
    function automatic longint center_mul(longint a, longint b);
        longint m;
        longint half;
        longint t;
        m = longint'(q_mod);
        if (m == 0)
            return 0;
        half = m / 2;
        t = (a * b) % m;
        if (t >= half)
            t -= m;
        if (t < -half)
            t += m;
        return t;
    endfunction

    // square-and-multiply from the lsb, then the factor step (scale mode: factor again, inverse n)
    function automatic t_twiddle_result predict_twiddle(logic [EXP_W-1:0] exponent,
                                                        logic scale);
        t_twiddle_result r;
        longint sq;
        longint acc;
        longint tw;
        logic [31:0] tw_word;
        sq  = longint'(root_reg);
        acc = 1;
        for (int i = 0; i < EXP_W; i++) begin
            if (exponent[i])
                acc = center_mul(acc, sq);
            sq = center_mul(sq, sq);
        end
        tw = center_mul(acc, longint'(mont_reg));
        if (scale) begin
            tw = center_mul(tw, longint'(mont_reg));
            tw = center_mul(tw, longint'(invn_reg));
        end
        tw_word    = tw[31:0];
        r.exponent = exponent;
        r.scale    = scale;
        r.twiddle  = tw[14:0];
        r.qinv     = tw_word * qinv_reg;
        return r;
    endfunction

    // mostly back to back, sometimes a short or medium gap, rarely a long pause
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 25);
        return $urandom_range(40, 140);
    endfunction

    function automatic logic [EXP_W-1:0] pick_exponent();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return EXP_W'(1) << $urandom_range(0, EXP_W - 1);
        return EXP_W'($urandom);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= MAX_PRINTED)
            $display("mismatch at %0t ns: %s", $time, what);
    endtask

    // one register write; the shadow copy follows the write at its edge
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        case (idx)
            REG_MODULUS:     q_mod    = data[14:0];
            REG_BASE_ROOT:   root_reg = data[14:0];
            REG_MONT_FACTOR: mont_reg = data[14:0];
            REG_INVERSE_N:   invn_reg = data[14:0];
            REG_Q_INVERSE:   qinv_reg = data;
            default: ;
        endcase
    endtask

    // full register set, only while idle; a spare index goes first and the
    // modulus last, since its write starts the reciprocal divide
    task automatic apply_settings(input logic [31:0] modulus, input logic [31:0] root,
                                  input logic [31:0] mont, input logic [31:0] invn,
                                  input logic [31:0] qinv);
        write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), $urandom);
        write_reg(REG_BASE_ROOT, root);
        write_reg(REG_MONT_FACTOR, mont);
        write_reg(REG_INVERSE_N, invn);
        write_reg(REG_Q_INVERSE, qinv);
        write_reg(REG_MODULUS, modulus);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // present one request and hold it until taken; valid stays high when
    // the next request follows with no gap
    task automatic send_request(input logic [EXP_W-1:0] exponent, input logic scale);
        int gap;
        i_in_valid   <= 1'b1;
        i_exponent   <= exponent;
        i_scale_mode <= scale;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        twiddle_expected.push_back(predict_twiddle(exponent, scale));
        requests_sent++;
        gap = idle_on ? pick_gap() : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (twiddle_expected.size() != 0)
            @(posedge i_clk);
    endtask

    // reset values of all registers: zero, all-ones, single-bit and alternating exponents, both modes
    task automatic test_reset_defaults();
        send_request(8'h00, 1'b0);
        send_request(8'h00, 1'b1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h01, 1'b0);
        send_request(8'h80, 1'b1);
        send_request(8'h55, 1'b0);
        send_request(8'hAA, 1'b1);
        drain_results();
    endtask

    // largest and smallest register values; upper data bits set on the
    // narrow registers must be dropped, and the root is left unreduced
    task automatic test_register_extremes();
        apply_settings('1, '1, '1, '1, '1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h00, 1'b1);
        send_request(8'h7F, 1'b0);
        drain_results();
        apply_settings(32'd3, 32'd0, 32'd0, 32'd0, 32'd0);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h3C, 1'b0);
        drain_results();
        apply_settings(32'hFFFF_8003, 32'd2, 32'd1, 32'd2, 32'd1);
        send_request(8'hFF, 1'b0);
        send_request(8'hFE, 1'b1);
        send_request(8'h01, 1'b1);
        drain_results();
    endtask

    // every modular reduction collapses to zero
    task automatic test_zero_modulus();
        apply_settings(32'd0, 32'd17, 32'd1353, 32'd3303, 32'd1806234369);
        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_request(8'h96, 1'b0);
        drain_results();
    endtask

    // random register sets, random requests; every third phase runs with
    // no idling on either side
    task automatic test_random_settings();
        logic [14:0] m;
        logic [14:0] root;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0:       m = 15'd3;
                1:       m = 15'h7FFF;
                2:       m = RST_MODULUS;
                default: m = 15'($urandom_range(3, 32767));
            endcase
            if ($urandom_range(0, 1) == 0)
                root = 15'($urandom_range(0, m - 1));
            else
                root = 15'($urandom);
            idle_on = (ph % 3) != 1;
            apply_settings({17'($urandom), m}, {17'($urandom), root}, $urandom,
                           $urandom, $urandom);
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_request(pick_exponent(), 1'($urandom));
            drain_results();
        end
    endtask

    // main sequence
    initial begin
        q_mod        = RST_MODULUS;
        root_reg     = RST_BASE_ROOT;
        mont_reg     = RST_MONT_FACTOR;
        invn_reg     = RST_INVERSE_N;
        qinv_reg     = RST_Q_INVERSE;
        i_rst_n      <= 1'b0;
        i_in_valid   <= 1'b0;
        i_exponent   <= '0;
        i_scale_mode <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_idx    <= REG_MODULUS;
        i_cfg_data   <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_zero_modulus();
        test_random_settings();

        // all requests answered; give the block time for any stray result
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("run covered %0d requests under %0d register settings plus reset values",
                 requests_sent, settings_used);
        $display("%0d results checked, %0d mismatching fields", results_checked,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // receiver stalls: random lengths, none while idling is off
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 4) == 0) begin
            stall_left  <= pick_gap();
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // result checker: each taken result against the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_twiddle_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (twiddle_expected.size() == 0) begin
                report_mismatch($sformatf("result twiddle %0d qinv %h with no request open",
                                          o_twiddle, o_twiddle_qinv));
            end else begin
                want = twiddle_expected.pop_front();
                results_checked++;
                if (o_twiddle !== want.twiddle)
                    report_mismatch($sformatf("exp %h scale %0b: twiddle %0d, expected %0d",
                                              want.exponent, want.scale, o_twiddle,
                                              want.twiddle));
                if (o_twiddle_qinv !== want.qinv)
                    report_mismatch($sformatf("exp %h scale %0b: qinv %h, expected %h",
                                              want.exponent, want.scale, o_twiddle_qinv,
                                              want.qinv));
            end
        end
    end

    // hang detection: any handshake or register write restarts the count
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= HANG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                     quiet_cycles, twiddle_expected.size());
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

@@ files.f @@
design/ntg_pkg.sv
design/ntg_recip.sv
design/ntg_seq.sv
design/ntg_datapath.sv
design/ntt_twiddle_generator.sv
bench/testbench.sv
